// ----- rtl/bgs_pkg.sv -----
`default_nettype none
package bgs_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int DIM_W = 9;
  localparam int CFG_IDX_W = 1;

  localparam int WQ_DEPTH = 4;
  localparam int WQ_PTR_W = $clog2(WQ_DEPTH);
  localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);

  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
  localparam int MAX_RES = 3;

  localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(24);
  localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(80);

  localparam logic [15:0] GLY_SPACE   = 16'h0020;
  localparam logic [15:0] GLY_H_HVY   = 16'h2501;
  localparam logic [15:0] GLY_V_HVY   = 16'h2503;
  localparam logic [15:0] GLY_TR_HVY  = 16'h2523;
  localparam logic [15:0] GLY_TL_HVY  = 16'h252B;
  localparam logic [15:0] GLY_TD_HVY  = 16'h2533;
  localparam logic [15:0] GLY_TU_HVY  = 16'h253B;
  localparam logic [15:0] GLY_X_HVY   = 16'h254B;
  localparam logic [15:0] GLY_H_LT    = 16'h2504;
  localparam logic [15:0] GLY_V_LT    = 16'h250A;
  localparam logic [15:0] GLY_TR_LT   = 16'h251C;
  localparam logic [15:0] GLY_TL_LT   = 16'h2524;
  localparam logic [15:0] GLY_TD_LT   = 16'h252C;
  localparam logic [15:0] GLY_TU_LT   = 16'h2534;
  localparam logic [15:0] GLY_X_LT    = 16'h253C;

  localparam logic [3:0] FG_FOCUSED = 4'd7;
  localparam logic [3:0] FG_NORMAL  = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_ROWS = 1'b0,
    CFG_SCREEN_COLS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic sep_h;
    logic sep_v;
    logic focus_adj;
  } in_item_t;

  typedef struct packed {
    logic f;
    logic v;
    logic h;
  } flags_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    flags_t           flags;
    logic             lastcol;
    logic             lastrow;
  } work_t;

  typedef struct packed {
    logic [7:0]  cell_row;
    logic [7:0]  cell_col;
    logic        write_cell;
    logic [15:0] glyph;
    logic [3:0]  fg_index;
    logic        last;
  } out_item_t;

  function automatic out_item_t make_result(
    input logic [ROW_W-1:0] row,
    input logic [COL_W-1:0] col,
    input flags_t           own,
    input logic             up,
    input logic             down,
    input logic             left,
    input logic             right
  );
    out_item_t   o;
    logic [15:0] g;
    o.cell_row = 8'(row);
    o.cell_col = 8'(col);
    o.last     = 1'b0;
    if (own.h && own.v) begin
      g = own.f ? GLY_X_HVY : GLY_X_LT;
    end else if (own.v) begin
      if (left && right)  g = own.f ? GLY_X_HVY : GLY_X_LT;
      else if (left)      g = own.f ? GLY_TL_HVY : GLY_TL_LT;
      else if (right)     g = own.f ? GLY_TR_HVY : GLY_TR_LT;
      else                g = own.f ? GLY_V_HVY : GLY_V_LT;
    end else if (own.h) begin
      if (up && down)     g = own.f ? GLY_X_HVY : GLY_X_LT;
      else if (up)        g = own.f ? GLY_TU_HVY : GLY_TU_LT;
      else if (down)      g = own.f ? GLY_TD_HVY : GLY_TD_LT;
      else                g = own.f ? GLY_H_HVY : GLY_H_LT;
    end else begin
      g = GLY_SPACE;
    end
    if (own == '0) begin
      o.write_cell = 1'b0;
      o.glyph      = '0;
      o.fg_index   = '0;
    end else begin
      o.write_cell = 1'b1;
      o.glyph      = g;
      o.fg_index   = own.f ? FG_FOCUSED : FG_NORMAL;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/border_glyph_stencil_top.sv -----
// Channel   Handshake                 Payload              Moves
// in_       in_push / in_full         in_data (in_item_t)  one screen cell per request
// out_      out_pop / out_empty       out_data (out_item_t) one border result per request
// cfg_      cfg_valid / cfg_ready     cfg_index, cfg_data  screen_rows, screen_cols
//
// Sustains one cell per clock; the front never waits on the back except through the
// four-entry work queue. A last-row cell makes up to three results and the output
// queue drains one per clock, so on the last row the output queue sets the pace.
// A result passes through the work queue, the back-end stage register and the output queue.
// in_full rises when the work queue fills behind a back end held for room for three results.
// Synchronous reset clears position, queues and sets the screen to 24 x 80; no sweep.
`default_nettype none
module border_glyph_stencil_top import bgs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire in_item_t             in_data,
  input  wire logic                 out_pop,
  output logic                      out_empty,
  output out_item_t                 out_data
);

  logic                     wq_full, wq_push, wq_valid, wq_pop, oq_room;
  work_t                    wq_in, wq_head;
  logic [1:0]               oq_push_n;
  out_item_t [MAX_RES-1:0]  oq_data;

  bgs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .wq_full   (wq_full),
    .wq_push   (wq_push),
    .wq_data   (wq_in)
  );

  bgs_work_q u_work_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (wq_push),
    .push_data (wq_in),
    .full      (wq_full),
    .pop       (wq_pop),
    .valid     (wq_valid),
    .head      (wq_head)
  );

  bgs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wq_valid  (wq_valid),
    .wq_data   (wq_head),
    .wq_pop    (wq_pop),
    .oq_room   (oq_room),
    .oq_push_n (oq_push_n),
    .oq_data   (oq_data)
  );

  bgs_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (oq_push_n),
    .push_data (oq_data),
    .room      (oq_room),
    .pop       (out_pop),
    .empty     (out_empty),
    .head      (out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/bgs_front.sv -----
`default_nettype none
module bgs_front import bgs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire in_item_t             in_data,
  input  wire logic                 wq_full,
  output logic                      wq_push,
  output work_t                     wq_data
);

  logic [DIM_W-1:0] rows_r, cols_r;
  logic [DIM_W-1:0] rows_cl, cols_cl;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             lastcol, lastrow, accept;

  assign cfg_ready = 1'b1;
  assign in_full   = wq_full;
  assign accept    = in_push && !wq_full;
  assign wq_push   = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
      cols_r <= COLS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SCREEN_ROWS: rows_r <= cfg_data;
        CFG_SCREEN_COLS: cols_r <= cfg_data;
      endcase
    end
  end

  // zero counts as one, oversize saturates
  always_comb begin
    if (rows_r == '0)                    rows_cl = DIM_W'(1);
    else if (rows_r > DIM_W'(MAX_ROWS))  rows_cl = DIM_W'(MAX_ROWS);
    else                                 rows_cl = rows_r;
    if (cols_r == '0)                    cols_cl = DIM_W'(1);
    else if (cols_r > DIM_W'(MAX_COLS))  cols_cl = DIM_W'(MAX_COLS);
    else                                 cols_cl = cols_r;
  end

  assign lastcol = (DIM_W'(col_r) + DIM_W'(1)) >= cols_cl;
  assign lastrow = (DIM_W'(row_r) + DIM_W'(1)) >= rows_cl;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (lastcol) begin
        col_nxt = '0;
        row_nxt = lastrow ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_comb begin
    wq_data.row     = row_r;
    wq_data.col     = col_r;
    wq_data.flags.h = in_data.sep_h;
    wq_data.flags.v = in_data.sep_v;
    wq_data.flags.f = in_data.focus_adj;
    wq_data.lastcol = lastcol;
    wq_data.lastrow = lastrow;
  end

endmodule
`default_nettype wire

// ----- rtl/bgs_work_q.sv -----
`default_nettype none
module bgs_work_q import bgs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire work_t push_data,
  output logic       full,
  input  wire logic  pop,
  output logic       valid,
  output work_t      head
);

  work_t               mem [WQ_DEPTH];
  logic [WQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [WQ_CNT_W-1:0] cnt_r;

  assign full  = cnt_r == WQ_CNT_W'(WQ_DEPTH);
  assign valid = cnt_r != '0;
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + WQ_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + WQ_PTR_W'(1);
      cnt_r <= cnt_r + WQ_CNT_W'(push) - WQ_CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bgs_back.sv -----
`default_nettype none
module bgs_back import bgs_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wq_valid,
  input  wire work_t               wq_data,
  output logic                     wq_pop,
  input  wire logic                oq_room,
  output logic [1:0]               oq_push_n,
  output out_item_t [MAX_RES-1:0]  oq_data
);

  flags_t prev_mem  [MAX_COLS];
  logic   older_mem [MAX_COLS];

  flags_t           rd_a_r, rd_b_r, byp_flags_r;
  logic             rd_o_r, byp_v_r, hit_a_r, hit_b_r;
  work_t            b2_r;
  logic             b2_valid_r, b2_go, load;
  flags_t           a_eff, b_eff, cur;
  logic             o_eff;
  flags_t           left_r, p1_r;
  logic             p2_h_r;
  logic [COL_W-1:0] ra, rb;
  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c;
  logic             v0, v1, v2;
  out_item_t        res0, res1, res2;
  logic [1:0]       n;

  assign b2_go  = b2_valid_r && oq_room;
  assign load   = wq_valid && (!b2_valid_r || b2_go);
  assign wq_pop = load;
  assign ra     = wq_data.col;
  assign rb     = wq_data.col + COL_W'(1);

  // write back the finished cell while the next one reads
  always_ff @(posedge clk) begin
    if (b2_go) begin
      prev_mem[b2_r.col]  <= cur;
      older_mem[b2_r.col] <= a_eff.v;
    end
    if (load) begin
      rd_a_r <= prev_mem[ra];
      rd_b_r <= prev_mem[rb];
      rd_o_r <= older_mem[ra];
    end
  end

  // forward the write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (load) begin
      hit_a_r     <= b2_go && (b2_r.col == ra);
      hit_b_r     <= b2_go && (b2_r.col == rb);
      byp_flags_r <= cur;
      byp_v_r     <= a_eff.v;
      b2_r        <= wq_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r <= 1'b0;
      left_r     <= '0;
      p1_r       <= '0;
      p2_h_r     <= 1'b0;
    end else begin
      if (load)       b2_valid_r <= 1'b1;
      else if (b2_go) b2_valid_r <= 1'b0;
      if (b2_go) begin
        left_r <= a_eff;
        p1_r   <= cur;
        p2_h_r <= p1_r.h;
      end
    end
  end

  assign a_eff = hit_a_r ? byp_flags_r : rd_a_r;
  assign b_eff = hit_b_r ? byp_flags_r : rd_b_r;
  assign o_eff = hit_a_r ? byp_v_r : rd_o_r;
  assign cur   = b2_r.flags;
  assign r     = b2_r.row;
  assign c     = b2_r.col;

  always_comb begin
    // cell above, finished by this one
    v0   = r != '0;
    res0 = make_result(r - ROW_W'(1), c, a_eff,
                       (r > ROW_W'(1)) && o_eff,
                       cur.v,
                       (c != '0) && left_r.h,
                       !b2_r.lastcol && (c != COL_W'(MAX_COLS - 1)) && b_eff.h);
    // last row: left neighbor in this row
    v1   = b2_r.lastrow && (c != '0);
    res1 = make_result(r, c - COL_W'(1), p1_r,
                       (r != '0) && left_r.v,
                       1'b0,
                       (c > COL_W'(1)) && p2_h_r,
                       cur.h);
    // last row, last column: this cell itself
    v2   = b2_r.lastrow && b2_r.lastcol;
    res2 = make_result(r, c, cur,
                       (r != '0) && a_eff.v,
                       1'b0,
                       (c != '0) && p1_r.h,
                       1'b0);
  end

  always_comb begin
    n = {1'b0, v0} + {1'b0, v1} + {1'b0, v2};
    oq_data[0] = v0 ? res0 : (v1 ? res1 : res2);
    oq_data[1] = (v0 && v1) ? res1 : res2;
    oq_data[2] = res2;
    for (int i = 0; i < MAX_RES; i++) begin
      oq_data[i].last = (2'(i) == (n - 2'd1));
    end
    oq_push_n = b2_go ? n : 2'd0;
  end

endmodule
`default_nettype wire

// ----- rtl/bgs_out_q.sv -----
`default_nettype none
module bgs_out_q import bgs_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [1:0]              push_n,
  input  wire out_item_t [MAX_RES-1:0] push_data,
  output logic                         room,
  input  wire logic                    pop,
  output logic                         empty,
  output out_item_t                    head
);

  out_item_t           mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CNT_W-1:0] cnt_r;
  logic                pop_ok;

  assign empty  = cnt_r == '0;
  assign room   = cnt_r <= OQ_CNT_W'(OQ_DEPTH - MAX_RES);
  assign head   = mem[rd_ptr_r];
  assign pop_ok = pop && !empty;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_n) mem[wr_ptr_r + OQ_PTR_W'(i)] <= push_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(push_n);
      if (pop_ok) rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(1);
      cnt_r <= cnt_r + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop_ok);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bgs_checker.sv -----
`default_nettype none
module bgs_checker import bgs_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_full,
  input wire logic                 out_pop,
  input wire logic                 out_empty,
  input wire out_item_t            out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed or vanished");

  // input back-pressure only comes from a backed-up result queue
  a_full_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input full while no result waits");

  a_glyph_color: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.write_cell &&
                    (out_data.fg_index == FG_FOCUSED || out_data.fg_index == FG_NORMAL)) ||
                   (!out_data.write_cell && out_data.glyph == '0 && out_data.fg_index == '0))
    else $error("glyph and color index disagree");

endmodule

bind border_glyph_stencil_top bgs_checker u_bgs_checker (.*);
`default_nettype wire

// ----- tb/tb_border_glyph_stencil_top.sv -----
module tb_border_glyph_stencil_top;
  import bgs_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SCREEN_ROWS;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  in_item_t             in_data = '0;
  logic                 out_pop = 1'b0;
  logic                 out_empty;
  out_item_t            out_data;

  border_glyph_stencil_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stencil state mirrored from the block.
  logic [DIM_W-1:0] scr_rows;
  logic [DIM_W-1:0] scr_cols;
  flags_t           row_above [MAX_COLS];
  logic             vbit_two_up [MAX_COLS];
  int unsigned      pos_row;
  int unsigned      pos_col;
  flags_t           left_above;

  out_item_t pending_glyphs[$];
  int        n_errors = 0;
  bit        in_lazy = 1'b1;
  bit        out_lazy = 1'b1;
  int        pop_hold = 0;

  typedef struct {
    bit               reconf;
    logic [DIM_W-1:0] rows_v;
    logic [DIM_W-1:0] cols_v;
    in_item_t         item;
    bit               typed;
    out_item_t        want;
  } step_t;

  step_t steps[$];

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned hi);
    if (v == '0) return 1;
    return (int'(v) > hi) ? hi : int'(v);
  endfunction

  function automatic logic [15:0] shape_glyph(flags_t own, logic up, logic down,
                                              logic left, logic right);
    logic [15:0] heavy;
    logic [15:0] light;
    logic        hook_a;
    logic        hook_b;
    heavy = GLY_SPACE;
    light = GLY_SPACE;
    if (own.h && own.v) begin
      heavy = GLY_X_HVY;
      light = GLY_X_LT;
    end else if (own.h || own.v) begin
      // a vertical line looks sideways, a horizontal one up and down
      hook_a = own.v ? left : up;
      hook_b = own.v ? right : down;
      case ({hook_a, hook_b})
        2'b11: begin
          heavy = GLY_X_HVY;
          light = GLY_X_LT;
        end
        2'b10: begin
          heavy = own.v ? GLY_TL_HVY : GLY_TU_HVY;
          light = own.v ? GLY_TL_LT : GLY_TU_LT;
        end
        2'b01: begin
          heavy = own.v ? GLY_TR_HVY : GLY_TD_HVY;
          light = own.v ? GLY_TR_LT : GLY_TD_LT;
        end
        default: begin
          heavy = own.v ? GLY_V_HVY : GLY_H_HVY;
          light = own.v ? GLY_V_LT : GLY_H_LT;
        end
      endcase
    end
    return own.f ? heavy : light;
  endfunction

  function automatic out_item_t finish_cell(int unsigned row, int unsigned col, flags_t own,
                                            logic up, logic down, logic left, logic right);
    out_item_t o;
    o = '0;
    o.cell_row = 8'(row);
    o.cell_col = 8'(col);
    if (own != '0) begin
      o.write_cell = 1'b1;
      o.glyph      = shape_glyph(own, up, down, left, right);
      o.fg_index   = own.f ? FG_FOCUSED : FG_NORMAL;
    end
    return o;
  endfunction

  // Advance the stencil by one cell and return the cells it finishes.
  task automatic stencil_step(input in_item_t it, output out_item_t res[$]);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    bit          lastcol;
    bit          lastrow;
    flags_t      cur;
    flags_t      above;
    logic        up;
    logic        left;
    logic        right;
    res = {};
    rows = eff_dim(scr_rows, MAX_ROWS);
    cols = eff_dim(scr_cols, MAX_COLS);
    r = pos_row;
    c = (pos_col < MAX_COLS) ? pos_col : MAX_COLS - 1;
    lastcol = (c + 1 >= cols);
    lastrow = (r + 1 >= rows);
    cur.h = it.sep_h;
    cur.v = it.sep_v;
    cur.f = it.focus_adj;
    above = row_above[c];

    if (r > 0) begin
      up = (r > 1) && vbit_two_up[c];
      left = (c > 0) && left_above.h;
      right = !lastcol && (c + 1 < MAX_COLS) && row_above[c + 1].h;
      res.push_back(finish_cell(r - 1, c, above, up, cur.v, left, right));
    end

    vbit_two_up[c] = above.v;
    left_above = above;
    row_above[c] = cur;

    if (lastrow) begin
      if (c > 0) begin
        up = (r > 0) && vbit_two_up[c - 1];
        left = (c > 1) && row_above[c - 2].h;
        res.push_back(finish_cell(r, c - 1, row_above[c - 1], up, 1'b0, left, cur.h));
      end
      if (lastcol) begin
        up = (r > 0) && vbit_two_up[c];
        left = (c > 0) && row_above[c - 1].h;
        res.push_back(finish_cell(r, c, cur, up, 1'b0, left, 1'b0));
      end
    end

    if (res.size() > 0) res[res.size() - 1].last = 1'b1;

    if (lastcol) begin
      pos_col = 0;
      left_above = '0;
      pos_row = lastrow ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end
  endtask

  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    out_item_t res[$];
    gap = in_lazy ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    stencil_step(it, res);
    if (typed) res = '{want};
    foreach (res[i]) pending_glyphs.push_back(res[i]);
  endtask

  // Wait out every pending result, then let the pipeline drain.
  task automatic settle();
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_screen(input logic [DIM_W-1:0] rows_v, input logic [DIM_W-1:0] cols_v);
    in_push <= 1'b0;
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SCREEN_ROWS;
    cfg_data <= rows_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    scr_rows = rows_v;
    cfg_index <= CFG_SCREEN_COLS;
    cfg_data <= cols_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    scr_cols = cols_v;
    cfg_valid <= 1'b0;
  endtask

  task automatic push_frame(output int sent);
    int       dens;
    int       total;
    in_item_t it;
    dens = $urandom_range(1, 3);
    in_lazy = ($urandom_range(0, 3) != 0);
    out_lazy = ($urandom_range(0, 3) != 0);
    total = eff_dim(scr_rows, MAX_ROWS) * eff_dim(scr_cols, MAX_COLS);
    for (int i = 0; i < total; i++) begin
      it.sep_h = ($urandom_range(0, 3) < dens);
      it.sep_v = ($urandom_range(0, 3) < dens);
      it.focus_adj = $urandom_range(0, 1);
      push_item(it, 1'b0, '0);
    end
    sent = total;
  endtask

  function automatic logic [DIM_W-1:0] pick_dim(int hi);
    if ($urandom_range(0, 7) == 0) return '0;
    return DIM_W'($urandom_range(1, hi));
  endfunction

  function automatic in_item_t mk_item(bit h, bit v, bit f);
    in_item_t it;
    it.sep_h = h;
    it.sep_v = v;
    it.focus_adj = f;
    return it;
  endfunction

  function automatic out_item_t lone(bit wr, logic [15:0] g, logic [3:0] fg);
    out_item_t o;
    o = '0;
    o.write_cell = wr;
    o.glyph = g;
    o.fg_index = fg;
    o.last = 1'b1;
    return o;
  endfunction

  function automatic step_t mk_step(bit reconf, int rows_v, int cols_v, in_item_t it,
                                    bit typed, out_item_t want);
    step_t s;
    s.reconf = reconf;
    s.rows_v = DIM_W'(rows_v);
    s.cols_v = DIM_W'(cols_v);
    s.item = it;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Result side: random pop stalls, compare each request against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_hold = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_glyphs.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, out_data);
          n_errors++;
        end else begin
          check_field("cell_row", pending_glyphs[0].cell_row, out_data.cell_row);
          check_field("cell_col", pending_glyphs[0].cell_col, out_data.cell_col);
          check_field("write_cell", pending_glyphs[0].write_cell, out_data.write_cell);
          check_field("glyph", pending_glyphs[0].glyph, out_data.glyph);
          check_field("fg_index", pending_glyphs[0].fg_index, out_data.fg_index);
          check_field("last", pending_glyphs[0].last, out_data.last);
          void'(pending_glyphs.pop_front());
        end
        pop_hold = out_lazy ? $urandom_range(0, 4) : 0;
      end
      if (pop_hold > 0) begin
        pop_hold--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main
    int sent;
    int rand_cells;
    int nfr;

    scr_rows = ROWS_RESET;
    scr_cols = COLS_RESET;
    for (int i = 0; i < MAX_COLS; i++) begin
      row_above[i] = '0;
      vbit_two_up[i] = 1'b0;
    end
    pos_row = 0;
    pos_col = 0;
    left_above = '0;

    // 1x1 screen (zero registers count as one): every flag mix, no neighbours.
    steps.push_back(mk_step(1, 0, 0, mk_item(0, 0, 0), 1, lone(0, 16'h0000, 4'd0)));
    steps.push_back(mk_step(0, 0, 0, mk_item(1, 0, 0), 1, lone(1, GLY_H_LT, FG_NORMAL)));
    steps.push_back(mk_step(0, 0, 0, mk_item(0, 1, 0), 1, lone(1, GLY_V_LT, FG_NORMAL)));
    steps.push_back(mk_step(0, 0, 0, mk_item(1, 1, 0), 1, lone(1, GLY_X_LT, FG_NORMAL)));
    steps.push_back(mk_step(0, 0, 0, mk_item(0, 0, 1), 1, lone(1, GLY_SPACE, FG_FOCUSED)));
    steps.push_back(mk_step(0, 0, 0, mk_item(1, 0, 1), 1, lone(1, GLY_H_HVY, FG_FOCUSED)));
    steps.push_back(mk_step(0, 0, 0, mk_item(0, 1, 1), 1, lone(1, GLY_V_HVY, FG_FOCUSED)));
    steps.push_back(mk_step(0, 0, 0, mk_item(1, 1, 1), 1, lone(1, GLY_X_HVY, FG_FOCUSED)));
    // 3x4 screen laid out for tees and crosses in both directions.
    steps.push_back(mk_step(1, 3, 4, mk_item(1, 0, 0), 0, '0));
    steps.push_back(mk_step(0, 0, 0, mk_item(0, 1, 0), 0, '0));
    steps.push_back(mk_step(0, 0, 0, mk_item(0, 1, 1), 0, '0));
    steps.push_back(mk_step(0, 0, 0, mk_item(1, 0, 0), 0, '0));
    steps.push_back(mk_step(0, 0, 0, mk_item(1, 0, 1), 0, '0));
    steps.push_back(mk_step(0, 0, 0, mk_item(1, 0, 0), 0, '0));
    steps.push_back(mk_step(0, 0, 0, mk_item(1, 0, 1), 0, '0));
    steps.push_back(mk_step(0, 0, 0, mk_item(0, 1, 0), 0, '0));
    steps.push_back(mk_step(0, 0, 0, mk_item(0, 0, 1), 0, '0));
    steps.push_back(mk_step(0, 0, 0, mk_item(0, 1, 0), 0, '0));
    steps.push_back(mk_step(0, 0, 0, mk_item(1, 1, 1), 0, '0));
    steps.push_back(mk_step(0, 0, 0, mk_item(1, 0, 0), 0, '0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) begin
      if (steps[i].reconf) set_screen(steps[i].rows_v, steps[i].cols_v);
      in_lazy = $urandom_range(0, 1);
      out_lazy = $urandom_range(0, 1);
      push_item(steps[i].item, steps[i].typed, steps[i].want);
    end

    // Saturated width: one full-width row.
    set_screen(9'd1, 9'd511);
    push_frame(sent);

    rand_cells = 0;
    while (rand_cells < 40) begin
      set_screen(pick_dim(6), pick_dim(10));
      nfr = $urandom_range(1, 2);
      repeat (nfr) begin
        push_frame(sent);
        rand_cells += sent;
      end
    end

    in_push <= 1'b0;
    settle();
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
